### rtl/mtsub_pkg.sv
// Shared types and constants for the midpoint triangle subdivider.
`default_nettype none
package mtsub_pkg;

   localparam int FRAC_BITS_DEF = 12;
   localparam int NFIELDS = 11;
   localparam int SUM_W = 17;

   // Field order within a vertex.
   localparam int F_POS_X = 0;
   localparam int F_POS_Y = 1;
   localparam int F_POS_Z = 2;
   localparam int F_NRM_X = 3;
   localparam int F_NRM_Y = 4;
   localparam int F_NRM_Z = 5;
   localparam int F_TNG_X = 6;
   localparam int F_TNG_Y = 7;
   localparam int F_TNG_Z = 8;
   localparam int F_TEX_U = 9;
   localparam int F_TEX_V = 10;

   // Output sequence position of the last corner and of the last midpoint.
   localparam logic [2:0] VTX_LAST_CORNER = 3'd2;
   localparam logic [2:0] VTX_LAST = 3'd5;
   localparam logic [2:0] VTX_MID01 = 3'd3;
   localparam logic [2:0] VTX_MID12 = 3'd4;

   typedef logic signed [15:0] field_type;
   typedef field_type vertex_type [NFIELDS];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OUT,
      ST_NSTART,
      ST_NWAIT,
      ST_TSTART,
      ST_TWAIT
   } state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_SQ,
      U_INIT,
      U_STEP1,
      U_STEP2,
      U_DONE
   } ustate_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] s0;
      logic signed [SUM_W-1:0] s1;
      logic signed [SUM_W-1:0] s2;
   } nrm_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] r0;
      logic [15:0] r1;
      logic [15:0] r2;
   } nrm_rsp_type;

endpackage
`default_nettype wire

### rtl/mtsub_nrm.sv
// Iterative vector normalizer: one squarer and one bit-per-step root search.
`default_nettype none
module mtsub_nrm
   import mtsub_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  nrm_req_type req,
   output nrm_rsp_type rsp
);

   localparam int WW = 2 * FRAC_BITS + 40;
   localparam int XW = FRAC_BITS + 1;
   localparam int KW = $clog2(FRAC_BITS + 1);
   localparam int RSH = 2 * FRAC_BITS + 2;

   ustate_type st_ff, st_in;
   logic signed [SUM_W-1:0] sv_ff [3];
   logic [2*SUM_W-1:0] sq_ff [3];
   logic [WW-1:0] len_ff, a_ff, b_ff, ac_ff, bc_ff;
   logic [1:0] idx_ff;
   logic [KW-1:0] k_ff;
   logic [XW-1:0] x_ff;
   logic [15:0] res_ff [3];

   logic signed [SUM_W-1:0] cur_s;
   logic [SUM_W-1:0] cur_abs;
   logic [2*SUM_W-1:0] cur_sq;
   logic [WW-1:0] f_val, r_val;
   logic [XW-1:0] x_new;
   logic fits;

   always_comb begin
      cur_s = sv_ff[idx_ff];
      cur_abs = cur_s[SUM_W-1] ? SUM_W'(-cur_s) : SUM_W'(cur_s);
      cur_sq = (2*SUM_W)'(cur_abs) * (2*SUM_W)'(cur_abs);
      // Trial test: (2x-1)^2 * L against |s|^2 * 4^(F+1).
      f_val = (ac_ff << 2) - (bc_ff << 2) + len_ff;
      r_val = WW'(sq_ff[idx_ff]) << RSH;
      fits = (f_val <= r_val);
      x_new = fits ? (x_ff | (XW'(1) << k_ff)) : x_ff;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         U_IDLE: if (req.start) st_in = U_SQ;
         U_SQ: if (idx_ff == 2'd2) st_in = U_INIT;
         U_INIT: st_in = (len_ff == '0) ? U_DONE : U_STEP1;
         U_STEP1: st_in = U_STEP2;
         U_STEP2: begin
            if (k_ff == '0 && idx_ff == 2'd2) st_in = U_DONE;
            else st_in = U_STEP1;
         end
         U_DONE: st_in = U_IDLE;
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= U_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         U_IDLE: begin
            sv_ff[0] <= req.s0;
            sv_ff[1] <= req.s1;
            sv_ff[2] <= req.s2;
            idx_ff <= 2'd0;
            len_ff <= '0;
         end
         U_SQ: begin
            sq_ff[idx_ff] <= cur_sq;
            len_ff <= len_ff + WW'(cur_sq);
            idx_ff <= idx_ff + 2'd1;
         end
         U_INIT: begin
            idx_ff <= 2'd0;
            x_ff <= '0;
            a_ff <= '0;
            b_ff <= '0;
            k_ff <= KW'(FRAC_BITS);
            res_ff[0] <= '0;
            res_ff[1] <= '0;
            res_ff[2] <= '0;
         end
         U_STEP1: begin
            // Candidate x + 2^k: x^2 L and x L updated by shifts and adds.
            ac_ff <= a_ff + (b_ff << (k_ff + KW'(1))) + (len_ff << (2 * k_ff));
            bc_ff <= b_ff + (len_ff << k_ff);
         end
         U_STEP2: begin
            if (k_ff == '0) begin
               res_ff[idx_ff] <= cur_s[SUM_W-1] ? -(16'(x_new)) : 16'(x_new);
               idx_ff <= idx_ff + 2'd1;
               x_ff <= '0;
               a_ff <= '0;
               b_ff <= '0;
               k_ff <= KW'(FRAC_BITS);
            end else begin
               if (fits) begin
                  a_ff <= ac_ff;
                  b_ff <= bc_ff;
               end
               x_ff <= x_new;
               k_ff <= k_ff - KW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.done = (st_ff == U_DONE);
   assign rsp.r0 = res_ff[0];
   assign rsp.r1 = res_ff[1];
   assign rsp.r2 = res_ff[2];

endmodule
`default_nettype wire

### rtl/midpoint_triangle_subdivider_core.sv
// Top level of the midpoint triangle subdivider.
// Operation: the first two corners are only stored; the third starts six output
// transactions, three corners right away, each midpoint after two normalizations.
// Both normalizations, of the normal and then of the tangent, run in the shared unit.
// Synchronous active-high reset clears the sequencer and the corner count.
`default_nettype none
module midpoint_triangle_subdivider_core
   import mtsub_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_pos_z,
   input  wire logic signed [15:0] req_norm_x,
   input  wire logic signed [15:0] req_norm_y,
   input  wire logic signed [15:0] req_norm_z,
   input  wire logic signed [15:0] req_tang_x,
   input  wire logic signed [15:0] req_tang_y,
   input  wire logic signed [15:0] req_tang_z,
   input  wire logic signed [15:0] req_tex_u,
   input  wire logic signed [15:0] req_tex_v,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [15:0] rsp_out_pos_x,
   output logic signed [15:0] rsp_out_pos_y,
   output logic signed [15:0] rsp_out_pos_z,
   output logic signed [15:0] rsp_out_norm_x,
   output logic signed [15:0] rsp_out_norm_y,
   output logic signed [15:0] rsp_out_norm_z,
   output logic signed [15:0] rsp_out_tang_x,
   output logic signed [15:0] rsp_out_tang_y,
   output logic signed [15:0] rsp_out_tang_z,
   output logic signed [15:0] rsp_out_tex_u,
   output logic signed [15:0] rsp_out_tex_v,
   output logic             rsp_last_of_triangle
);

   state_type st_ff, st_in;
   logic [1:0] cnt_ff;
   logic [2:0] vtx_ff;
   vertex_type c0_ff, c1_ff, c2_ff, in_v, va, vb, vo;
   field_type nrm_ff [3];
   field_type tng_ff [3];
   nrm_req_type nreq;
   nrm_rsp_type nrsp;
   logic req_acc, rsp_acc;

   assign in_v[F_POS_X] = req_pos_x;
   assign in_v[F_POS_Y] = req_pos_y;
   assign in_v[F_POS_Z] = req_pos_z;
   assign in_v[F_NRM_X] = req_norm_x;
   assign in_v[F_NRM_Y] = req_norm_y;
   assign in_v[F_NRM_Z] = req_norm_z;
   assign in_v[F_TNG_X] = req_tang_x;
   assign in_v[F_TNG_Y] = req_tang_y;
   assign in_v[F_TNG_Z] = req_tang_z;
   assign in_v[F_TEX_U] = req_tex_u;
   assign in_v[F_TEX_V] = req_tex_v;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // Edge endpoints for the midpoint being produced or shown.
   always_comb begin
      case (vtx_ff)
         VTX_MID01: begin
            va = c0_ff;
            vb = c1_ff;
         end
         VTX_MID12: begin
            va = c1_ff;
            vb = c2_ff;
         end
         default: begin
            va = c0_ff;
            vb = c2_ff;
         end
      endcase
   end

   mtsub_nrm #(.FRAC_BITS(FRAC_BITS)) u_nrm (
      .clock(clock),
      .reset(reset),
      .req(nreq),
      .rsp(nrsp)
   );

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req_acc && cnt_ff == 2'd2) st_in = ST_OUT;
         ST_OUT: begin
            if (rsp_acc) begin
               if (vtx_ff == VTX_LAST) st_in = ST_IDLE;
               else if (vtx_ff >= VTX_LAST_CORNER) st_in = ST_NSTART;
            end
         end
         ST_NSTART: st_in = ST_NWAIT;
         ST_NWAIT: if (nrsp.done) st_in = ST_TSTART;
         ST_TSTART: st_in = ST_TWAIT;
         ST_TWAIT: if (nrsp.done) st_in = ST_OUT;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (st_ff != ST_IDLE);
      rsp_valid = (st_ff == ST_OUT);
      nreq.start = (st_ff == ST_NSTART) || (st_ff == ST_TSTART);
      if (st_ff == ST_NSTART) begin
         nreq.s0 = SUM_W'(va[F_NRM_X]) + SUM_W'(vb[F_NRM_X]);
         nreq.s1 = SUM_W'(va[F_NRM_Y]) + SUM_W'(vb[F_NRM_Y]);
         nreq.s2 = SUM_W'(va[F_NRM_Z]) + SUM_W'(vb[F_NRM_Z]);
      end else begin
         nreq.s0 = SUM_W'(va[F_TNG_X]) + SUM_W'(vb[F_TNG_X]);
         nreq.s1 = SUM_W'(va[F_TNG_Y]) + SUM_W'(vb[F_TNG_Y]);
         nreq.s2 = SUM_W'(va[F_TNG_Z]) + SUM_W'(vb[F_TNG_Z]);
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] sum;
      for (int i = 0; i < NFIELDS; i++) begin
         sum = SUM_W'(va[i]) + SUM_W'(vb[i]);
         vo[i] = 16'(sum >>> 1);
      end
      vo[F_NRM_X] = nrm_ff[0];
      vo[F_NRM_Y] = nrm_ff[1];
      vo[F_NRM_Z] = nrm_ff[2];
      vo[F_TNG_X] = tng_ff[0];
      vo[F_TNG_Y] = tng_ff[1];
      vo[F_TNG_Z] = tng_ff[2];
      case (vtx_ff)
         3'd0: vo = c0_ff;
         3'd1: vo = c1_ff;
         VTX_LAST_CORNER: vo = c2_ff;
         default: begin
         end
      endcase
   end

   assign rsp_out_pos_x = vo[F_POS_X];
   assign rsp_out_pos_y = vo[F_POS_Y];
   assign rsp_out_pos_z = vo[F_POS_Z];
   assign rsp_out_norm_x = vo[F_NRM_X];
   assign rsp_out_norm_y = vo[F_NRM_Y];
   assign rsp_out_norm_z = vo[F_NRM_Z];
   assign rsp_out_tang_x = vo[F_TNG_X];
   assign rsp_out_tang_y = vo[F_TNG_Y];
   assign rsp_out_tang_z = vo[F_TNG_Z];
   assign rsp_out_tex_u = vo[F_TEX_U];
   assign rsp_out_tex_v = vo[F_TEX_V];
   assign rsp_last_of_triangle = (vtx_ff == VTX_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= 2'd0;
         vtx_ff <= 3'd0;
      end else begin
         st_ff <= st_in;
         if (req_acc) begin
            cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
            vtx_ff <= 3'd0;
         end
         if (rsp_acc) vtx_ff <= vtx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         case (cnt_ff)
            2'd0: c0_ff <= in_v;
            2'd1: c1_ff <= in_v;
            default: c2_ff <= in_v;
         endcase
      end
      if (nrsp.done && st_ff == ST_NWAIT) begin
         nrm_ff[0] <= nrsp.r0;
         nrm_ff[1] <= nrsp.r1;
         nrm_ff[2] <= nrsp.r2;
      end
      if (nrsp.done && st_ff == ST_TWAIT) begin
         tng_ff[0] <= nrsp.r0;
         tng_ff[1] <= nrsp.r1;
         tng_ff[2] <= nrsp.r2;
      end
   end

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      nrsp.done |-> (st_ff == ST_NWAIT || st_ff == ST_TWAIT))
      else $error("normalizer finished outside a wait state");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("corner count out of range");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_last_of_triangle) |=> (!rsp_valid && !req_stall))
      else $error("block did not return to idle after the last vertex");

   a_no_out_during_norm: assert property (@(posedge clock) disable iff (reset)
      nreq.start |=> !rsp_valid)
      else $error("vertex shown while a normalization runs");

endmodule
`default_nettype wire
